### design/dsd_pkg.sv
// shared types, constants and verdict decode for the dtls/srtp packet demux
package dsd_pkg;

    localparam int MAX_PACKET_BYTES = 2048;
    localparam int CNT_W            = $clog2(MAX_PACKET_BYTES + 1);
    localparam int LEN_W            = 12;
    localparam int POS_W            = 4;
    localparam int REM_W            = 16;

    localparam int HDR_LEN      = 13;
    localparam int HDR_LAST_POS = 12;
    localparam int LEN_HIGH_POS = 11;
    localparam int HELLO_POS    = 13;
    localparam int RTP_MIN      = 12;
    localparam int HELLO_MIN    = 17;
    localparam int DTLS_LO      = 19;
    localparam int DTLS_HI      = 64;
    localparam logic [7:0] HANDSHAKE_TYPE = 8'd22;
    localparam logic [7:0] HELLO_TYPE     = 8'd1;
    localparam logic [7:0] RTP_MASK       = 8'hC0;
    localparam logic [7:0] RTP_VER        = 8'h80;

    typedef enum logic [2:0] {
        LINK_NEW        = 3'd0,
        LINK_CONNECTING = 3'd1,
        LINK_CONNECTED  = 3'd2,
        LINK_FAILED     = 3'd3,
        LINK_CLOSED     = 3'd4
    } t_link_state;

    typedef enum logic [2:0] {
        VERD_DROP        = 3'd0,
        VERD_CACHE_HELLO = 3'd1,
        VERD_FWD_DTLS    = 3'd2,
        VERD_MALFORMED   = 3'd3,
        VERD_EARLY       = 3'd4,
        VERD_NOT_RTP     = 3'd5,
        VERD_SRTP_BYPASS = 3'd6,
        VERD_CLOSED_DROP = 3'd7
    } t_verdict;

    // per-packet summary as it stands after the current byte
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [7:0]       lead;
        logic             hello;
        logic             tiled;
    } t_pkt_summary;

    function automatic t_verdict f_verdict(input logic [2:0] link, input t_pkt_summary s);
        logic     is_dtls;
        logic     is_hello;
        logic     is_rtp;
        t_verdict v;
        is_dtls  = (s.count >= CNT_W'(HDR_LEN)) && (s.lead > 8'(DTLS_LO))
                   && (s.lead < 8'(DTLS_HI));
        is_hello = is_dtls && (s.count > CNT_W'(HELLO_MIN))
                   && (s.lead == HANDSHAKE_TYPE) && s.hello;
        is_rtp   = (s.count >= CNT_W'(RTP_MIN)) && ((s.lead & RTP_MASK) == RTP_VER);
        unique case (link)
            LINK_NEW: begin
                v = is_hello ? VERD_CACHE_HELLO : VERD_DROP;
            end
            LINK_CONNECTING, LINK_CONNECTED: begin
                if (is_dtls) begin
                    v = s.tiled ? VERD_FWD_DTLS : VERD_MALFORMED;
                end else if (link != LINK_CONNECTED) begin
                    v = VERD_EARLY;
                end else if (!is_rtp) begin
                    v = VERD_NOT_RTP;
                end else begin
                    v = VERD_SRTP_BYPASS;
                end
            end
            LINK_FAILED: begin
                v = VERD_DROP;
            end
            default: begin
                v = VERD_CLOSED_DROP;
            end
        endcase
        return v;
    endfunction

endpackage

### design/dsd_tracker.sv
// per-packet byte counter, lead byte capture and dtls record header walk
module dsd_tracker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    output dsd_pkg::t_pkt_summary o_sum
);

    logic [dsd_pkg::CNT_W-1:0] r_count, n_count;
    logic [7:0]                r_lead, n_lead;
    logic                      r_hello, n_hello;
    logic [dsd_pkg::POS_W-1:0] r_pos, n_pos;
    logic [7:0]                r_high, n_high;
    logic [dsd_pkg::REM_W-1:0] r_rem, n_rem;
    logic                      r_in_body, n_in_body;

    always_comb begin
        n_lead    = (r_count == '0) ? i_byte : r_lead;
        n_hello   = r_hello || ((r_count == dsd_pkg::CNT_W'(dsd_pkg::HELLO_POS))
                                && (i_byte == dsd_pkg::HELLO_TYPE));
        n_count   = (r_count < dsd_pkg::CNT_W'(dsd_pkg::MAX_PACKET_BYTES))
                    ? r_count + 1'b1 : r_count;
        n_pos     = r_pos;
        n_high    = r_high;
        n_rem     = r_rem;
        n_in_body = r_in_body;
        if (r_in_body) begin
            n_rem = r_rem - 1'b1;
            if (n_rem == '0) begin
                n_in_body = 1'b0;
                n_pos     = '0;
            end
        end else begin
            if (r_pos == dsd_pkg::POS_W'(dsd_pkg::LEN_HIGH_POS)) begin
                n_high = i_byte;
            end
            if (r_pos >= dsd_pkg::POS_W'(dsd_pkg::HDR_LAST_POS)) begin
                n_rem     = {r_high, i_byte};
                n_pos     = '0;
                n_in_body = ({r_high, i_byte} != 16'd0);
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    assign o_sum.count = n_count;
    assign o_sum.lead  = n_lead;
    assign o_sum.hello = n_hello;
    assign o_sum.tiled = (n_pos == '0) && !n_in_body;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_lead    <= '0;
            r_hello   <= 1'b0;
            r_pos     <= '0;
            r_high    <= '0;
            r_rem     <= '0;
            r_in_body <= 1'b0;
        end else if (i_step) begin
            if (i_last) begin
                r_count   <= '0;
                r_lead    <= '0;
                r_hello   <= 1'b0;
                r_pos     <= '0;
                r_high    <= '0;
                r_rem     <= '0;
                r_in_body <= 1'b0;
            end else begin
                r_count   <= n_count;
                r_lead    <= n_lead;
                r_hello   <= n_hello;
                r_pos     <= n_pos;
                r_high    <= n_high;
                r_rem     <= n_rem;
                r_in_body <= n_in_body;
            end
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= dsd_pkg::POS_W'(dsd_pkg::HDR_LAST_POS))
        else $error("record header position out of range");

    a_body_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_body |-> (r_pos == '0) && (r_rem != '0))
        else $error("record body state inconsistent");

    a_fresh_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_pos == '0) && !r_in_body && !r_hello)
        else $error("stale per-packet state at packet start");

endmodule

### design/dtls_srtp_packet_demux.sv
// top level of the dtls/srtp receive packet demultiplexer
// Received packets stream in one byte per item, i_last_byte marking the final
// byte. Each byte is captured in an input register, then the per-packet
// tracker (byte count saturating at the package maximum, lead byte,
// clienthello type check, 13-byte dtls record header walk) advances on it.
// On the final byte the verdict is decoded from the transport state in
// i_cfg_data as last written and the packet summary, and lands in the result
// register together with the packet length; non-final bytes give no result.
// Rate: one byte per cycle sustained; o_out_valid is driven from the result
// register. Only a final byte can be held up, and only while the result
// register is full and stalled: it then waits in the input register and the
// byte input stalls behind it for as long as the result stays stalled. With
// no result stall there are no bubbles. Write i_cfg_data only while no
// packet is in flight; codes 5..7 act as closed.
module dtls_srtp_packet_demux (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_data,
    // byte input channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [7:0]                 i_data_byte,
    input  logic                       i_last_byte,
    // verdict output channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [2:0]                 o_verdict,
    output logic [dsd_pkg::LEN_W-1:0]  o_packet_length
);

    // transport state register
    logic [2:0] r_link;

    // input register stage
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_last;

    // result register
    logic                      r_out_valid;
    logic [2:0]                r_verdict;
    logic [dsd_pkg::LEN_W-1:0] r_len;

    logic                  out_free;
    logic                  s1_move;
    logic                  in_take;
    dsd_pkg::t_pkt_summary sum;
    dsd_pkg::t_verdict     verd;

    // result slot frees when empty or being taken this cycle
    assign out_free = !r_out_valid || !i_out_stall;
    // a non-final byte never waits; a final byte needs a free result slot
    assign s1_move  = r_s1_valid && (!r_s1_last || out_free);
    assign in_take  = i_in_valid && !o_in_stall;

    assign o_in_stall = r_s1_valid && !s1_move;

    dsd_tracker u_tracker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (s1_move),
        .i_byte  (r_s1_byte),
        .i_last  (r_s1_last),
        .o_sum   (sum)
    );

    assign verd = dsd_pkg::f_verdict(r_link, sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= dsd_pkg::LINK_NEW;
        end else if (i_cfg_we) begin
            r_link <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_byte <= i_data_byte;
            r_s1_last <= i_last_byte;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && r_s1_last) begin
            r_verdict <= verd;
            r_len     <= dsd_pkg::LEN_W'(sum.count);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_verdict       = r_verdict;
    assign o_packet_length = r_len;

    a_result_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_s1_valid && r_s1_last))
        else $error("result appeared without a final byte");

    a_mid_byte_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_s1_last) |-> s1_move)
        else $error("non-final byte held in input register");

    a_final_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last && r_out_valid && i_out_stall)
        |=> (r_s1_valid && r_s1_last && r_out_valid))
        else $error("final byte or pending result lost under stall");

endmodule

### dv/tb_dtls_srtp_packet_demux.sv
// testbench for the dtls/srtp packet demux: byte stimulus, verdict prediction and checking
`timescale 1ns / 100ps

// widths and limits of the per-packet tracking, kept at the block's sizes
localparam logic [11:0] HDR_BYTES       = 12'd13;
localparam logic [11:0] RTP_MIN_BYTES   = 12'd12;
localparam logic [11:0] HELLO_MIN_BYTES = 12'd17;
localparam logic [11:0] HELLO_AT        = 12'd13;
localparam logic [11:0] COUNT_MAX       = 12'(dsd_pkg::MAX_PACKET_BYTES);
localparam logic [3:0]  LEN_HI_POS      = 4'd11;
localparam logic [3:0]  LEN_LO_POS      = 4'd12;
localparam logic [7:0]  CT_HANDSHAKE    = 8'd22;
localparam logic [7:0]  HELLO_MSG       = 8'd1;
localparam logic [7:0]  DTLS_FIRST      = 8'd20;
localparam logic [7:0]  DTLS_LAST       = 8'd63;
localparam logic [1:0]  RTP_TOP_BITS    = 2'b10;

// link codes the package leaves unnamed, all of them act as closed
localparam logic [2:0]  LINK_SPARE5     = 3'd5;
localparam logic [2:0]  LINK_SPARE6     = 3'd6;
localparam logic [2:0]  LINK_SPARE7     = 3'd7;

typedef struct packed {
    dsd_pkg::t_verdict verdict;
    logic [11:0]       length;
} t_verdict_rec;

// tracks the packet in flight and keeps the verdicts still owed by the block
class demux_scoreboard;
    logic [2:0]   link;
    logic [11:0]  pkt_count;
    logic [7:0]   first_byte;
    bit           hello_flag;
    logic [3:0]   hdr_pos;
    logic [7:0]   len_hi;
    logic [15:0]  body_left;
    bit           in_body;
    t_verdict_rec owed_q[$];
    int           errors;

    function new();
        link   = dsd_pkg::LINK_NEW;
        errors = 0;
        clear_packet();
    endfunction

    function void clear_packet();
        pkt_count  = '0;
        first_byte = '0;
        hello_flag = 0;
        hdr_pos    = '0;
        len_hi     = '0;
        body_left  = '0;
        in_body    = 0;
    endfunction

    function int pending();
        return owed_q.size();
    endfunction

    // one accepted byte: advance the packet state, owe a verdict on the final byte
    function void note_byte(logic [7:0] b, logic fin);
        bit           is_dtls;
        bit           is_hello;
        bit           is_rtp;
        bit           tiled;
        t_verdict_rec rec;
        if (pkt_count == '0) first_byte = b;
        if (pkt_count == HELLO_AT && b == HELLO_MSG) hello_flag = 1;
        // record walk: 13 header bytes, length big endian in the last two
        if (in_body) begin
            body_left = body_left - 16'd1;
            if (body_left == '0) begin
                in_body = 0;
                hdr_pos = '0;
            end
        end else if (hdr_pos == LEN_LO_POS) begin
            body_left = {len_hi, b};
            hdr_pos   = '0;
            in_body   = (body_left != '0);
        end else begin
            if (hdr_pos == LEN_HI_POS) len_hi = b;
            hdr_pos = hdr_pos + 4'd1;
        end
        if (pkt_count < COUNT_MAX) pkt_count = pkt_count + 12'd1;
        if (!fin) return;

        tiled    = (hdr_pos == '0) && !in_body;
        is_dtls  = pkt_count >= HDR_BYTES && first_byte >= DTLS_FIRST
                   && first_byte <= DTLS_LAST;
        is_hello = is_dtls && pkt_count > HELLO_MIN_BYTES
                   && first_byte == CT_HANDSHAKE && hello_flag;
        is_rtp   = pkt_count >= RTP_MIN_BYTES && first_byte[7:6] == RTP_TOP_BITS;
        case (link)
            dsd_pkg::LINK_NEW: begin
                rec.verdict = is_hello ? dsd_pkg::VERD_CACHE_HELLO : dsd_pkg::VERD_DROP;
            end
            dsd_pkg::LINK_CONNECTING: begin
                if (is_dtls) rec.verdict = tiled ? dsd_pkg::VERD_FWD_DTLS
                                                 : dsd_pkg::VERD_MALFORMED;
                else         rec.verdict = dsd_pkg::VERD_EARLY;
            end
            dsd_pkg::LINK_CONNECTED: begin
                if (is_dtls)     rec.verdict = tiled ? dsd_pkg::VERD_FWD_DTLS
                                                     : dsd_pkg::VERD_MALFORMED;
                else if (is_rtp) rec.verdict = dsd_pkg::VERD_SRTP_BYPASS;
                else             rec.verdict = dsd_pkg::VERD_NOT_RTP;
            end
            dsd_pkg::LINK_FAILED: begin
                rec.verdict = dsd_pkg::VERD_DROP;
            end
            default: begin
                rec.verdict = dsd_pkg::VERD_CLOSED_DROP;
            end
        endcase
        rec.length = pkt_count;
        owed_q.push_back(rec);
        clear_packet();
    endfunction

    // one accepted verdict against the oldest one owed
    function void check_result(logic [2:0] verdict, logic [11:0] length);
        t_verdict_rec rec;
        if (owed_q.size() == 0) begin
            $display("%0t: unexpected verdict %0d length %0d", $time, verdict, length);
            errors++;
            return;
        end
        rec = owed_q.pop_front();
        if (verdict !== rec.verdict) begin
            $display("%0t: verdict mismatch, expected %0d actual %0d",
                     $time, rec.verdict, verdict);
            errors++;
        end
        if (length !== rec.length) begin
            $display("%0t: packet length mismatch, expected %0d actual %0d",
                     $time, rec.length, length);
            errors++;
        end
    endfunction
endclass

module tb_dtls_srtp_packet_demux;

    // run ends in failure past this many cycles
    localparam int CYCLE_LIMIT  = 500000;
    // random part stops once both of these are reached
    localparam int RANDOM_BYTES = 1350;
    localparam int RANDOM_PKTS  = 48;
    localparam int HOLD_CYCLES  = 200;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_we     = 1'b0;
    logic [2:0]  i_cfg_data   = '0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte  = '0;
    logic        i_last_byte  = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall  = 1'b0;
    logic [2:0]  o_verdict;
    logic [dsd_pkg::LEN_W-1:0] o_packet_length;

    demux_scoreboard sb;
    logic [7:0]  pkt[$];       // bytes of the packet about to be sent
    bit          no_gaps  = 0; // sender runs back to back while set
    bit          hold_req = 0; // asks the receiver for one long hold-off
    int          cycle_count = 0;

    dtls_srtp_packet_demux uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_verdict       (o_verdict),
        .o_packet_length (o_packet_length)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // verdict monitor, sampled on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_verdict, o_packet_length);
        end
    end

    // receiver: runs of stall and no stall, mostly short, some long, some quiet
    // stretches, plus one long hold-off on request counted here
    initial begin
        int seg_left;
        int hold_left;
        int r;
        seg_left  = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 0;
                hold_left = HOLD_CYCLES;
                seg_left  = 0;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (seg_left > 0) begin
                seg_left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    i_out_stall <= 1'b0;
                    seg_left = $urandom_range(0, 3);
                end else if (r < 80) begin
                    i_out_stall <= 1'b1;
                    seg_left = $urandom_range(0, 2);
                end else if (r < 92) begin
                    i_out_stall <= 1'b0;
                    seg_left = $urandom_range(30, 120);
                end else begin
                    i_out_stall <= 1'b1;
                    seg_left = $urandom_range(20, 50);
                end
            end
        end
    end

    // idle cycles after a byte: mostly none, a few long
    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // offer one byte at the falling edge and hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic fin);
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= fin;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_byte(b, fin);
        @(negedge i_clk);
    endtask

    // valid only drops when a gap follows, so a back-to-back byte never
    // sees valid lowered and raised in the same step
    task automatic send_packet();
        int gap;
        for (int i = 0; i < pkt.size(); i++) begin
            send_byte(pkt[i], i == pkt.size() - 1);
            gap = pick_gap();
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // dtls record: content type, ten filler bytes, 16-bit length, body
    task automatic add_record(input logic [7:0] ctype, input int body_len,
                              input bit hello_body);
        pkt.push_back(ctype);
        repeat (10) pkt.push_back(8'($urandom_range(0, 255)));
        pkt.push_back(body_len[15:8]);
        pkt.push_back(body_len[7:0]);
        for (int i = 0; i < body_len; i++) begin
            if (hello_body && i == 0) pkt.push_back(HELLO_MSG);
            else                      pkt.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // given first byte, random rest
    task automatic make_plain(input logic [7:0] lead, input int len);
        pkt.delete();
        pkt.push_back(lead);
        repeat (len - 1) pkt.push_back(8'($urandom_range(0, 255)));
    endtask

    // mostly well-formed dtls with random content, then rtp, noise and
    // dtls-looking packets with garbage headers
    task automatic make_random_packet();
        int         kind;
        int         nrec;
        int         blen;
        bit         hello;
        logic [7:0] lead;
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            pkt.delete();
            hello = ($urandom_range(0, 2) == 0);
            lead  = hello ? CT_HANDSHAKE : 8'($urandom_range(20, 63));
            nrec  = $urandom_range(1, 3);
            for (int r = 0; r < nrec; r++) begin
                blen = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 20);
                if (r == 0) begin
                    if (hello && blen == 0) blen = 1;
                    add_record(lead, blen, hello);
                end else begin
                    add_record(8'($urandom_range(20, 63)), blen, 0);
                end
            end
            // break the tiling now and then
            if ($urandom_range(0, 4) == 0) begin
                if ($urandom_range(0, 1) == 0) begin
                    repeat ($urandom_range(1, 5)) begin
                        if (pkt.size() > 1) void'(pkt.pop_back());
                    end
                end else begin
                    repeat ($urandom_range(1, 5)) pkt.push_back(8'($urandom_range(0, 255)));
                end
            end
        end else if (kind < 80) begin
            make_plain({RTP_TOP_BITS, 6'($urandom())}, $urandom_range(1, 40));
        end else if (kind < 90) begin
            make_plain(8'($urandom_range(0, 255)), $urandom_range(1, 30));
        end else begin
            make_plain(8'($urandom_range(20, 63)), $urandom_range(13, 30));
        end
    endtask

    // stop offering, wait for every owed verdict, then let the pipe drain
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // link state is only written with nothing in flight
    task automatic begin_phase(input logic [2:0] link);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= link;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.link = link;
    endtask

    initial begin
        logic [2:0] link_plan [8];
        int         rand_bytes;
        int         rand_pkts;
        int         phase;
        int         n;

        sb = new();
        link_plan = '{dsd_pkg::LINK_NEW, LINK_SPARE7, dsd_pkg::LINK_CONNECTED,
                      dsd_pkg::LINK_CONNECTING, dsd_pkg::LINK_FAILED,
                      dsd_pkg::LINK_CLOSED, LINK_SPARE5, LINK_SPARE6};
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- directed: clienthello edges while new
        begin_phase(dsd_pkg::LINK_NEW);
        pkt.delete(); add_record(CT_HANDSHAKE, 5, 1); send_packet();  // 18 bytes, cached
        pkt.delete(); add_record(CT_HANDSHAKE, 4, 1); send_packet();  // 17 bytes, too short
        pkt.delete(); add_record(CT_HANDSHAKE, 5, 1);                 // wrong handshake type
        pkt[13] = 8'h00;
        send_packet();
        pkt.delete(); add_record(8'd23, 5, 1); send_packet();         // not a handshake record

        // ---- directed: dtls range, rtp range, lengths and tiling while connected
        begin_phase(dsd_pkg::LINK_CONNECTED);
        pkt.delete(); add_record(8'd19, 0, 0); send_packet();         // just below dtls range
        pkt.delete(); add_record(DTLS_FIRST, 0, 0); send_packet();    // empty record, tiled
        pkt.delete(); add_record(DTLS_LAST, 0, 0); send_packet();
        pkt.delete(); add_record(8'd64, 0, 0); send_packet();         // just above dtls range
        make_plain(DTLS_FIRST, 12); send_packet();                    // one byte short of dtls
        make_plain(8'h80, 11); send_packet();                         // one byte short of rtp
        make_plain(8'h80, 12); send_packet();
        make_plain(8'hBF, 12); send_packet();
        make_plain(8'hC0, 12); send_packet();
        make_plain(8'h00, 1); send_packet();
        make_plain(8'hFF, 1); send_packet();
        pkt.delete();                                                 // two records, one extra byte
        add_record(DTLS_FIRST, 3, 0);
        add_record(8'd21, 0, 0);
        pkt.push_back(8'h5A);
        send_packet();
        pkt.delete();                                                 // record length far past the end
        add_record(DTLS_FIRST, 0, 0);
        pkt[11] = 8'hFF;
        pkt[12] = 8'hFF;
        repeat (5) pkt.push_back(8'($urandom_range(0, 255)));
        send_packet();
        pkt.delete(); add_record(8'd23, 2087, 0); send_packet();      // saturating count, tiled

        // ---- directed: connecting
        begin_phase(dsd_pkg::LINK_CONNECTING);
        make_plain(8'h80, 12); send_packet();
        pkt.delete(); add_record(DTLS_FIRST, 2, 0); send_packet();

        // ---- random phases, each link code once first, then at random
        rand_bytes = 0;
        rand_pkts  = 0;
        phase      = 0;
        while (rand_bytes < RANDOM_BYTES || rand_pkts < RANDOM_PKTS) begin
            begin_phase(phase < 8 ? link_plan[phase] : 3'($urandom_range(0, 7)));
            if (phase == 2) begin
                // receiver holds off while tiny packets keep coming, so the
                // block backs up and stalls its byte input
                hold_req = 1;
                no_gaps  = 1;
                repeat (14) begin
                    make_plain(8'($urandom_range(0, 255)), $urandom_range(1, 3));
                    send_packet();
                    rand_bytes += pkt.size();
                    rand_pkts++;
                end
                no_gaps = 0;
                wait_idle();  // sender pauses until every verdict is in
            end
            no_gaps = ($urandom_range(0, 3) == 0);
            n = $urandom_range(3, 8);
            repeat (n) begin
                make_random_packet();
                send_packet();
                rand_bytes += pkt.size();
                rand_pkts++;
            end
            no_gaps = 0;
            phase++;
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
design/dsd_pkg.sv
design/dsd_tracker.sv
design/dtls_srtp_packet_demux.sv
dv/tb_dtls_srtp_packet_demux.sv
